// File: sv/dcfu_pkg.sv
`default_nettype none
package dcfu_pkg;

  // Decay factor format and Horner length
  localparam int DECAY_BITS   = 30;
  localparam int HORNER_STEPS = 10;
  localparam int POW_COUNT    = 5;

  // Register indexes
  localparam logic CFG_TIME_STEP = 1'b0;
  localparam logic CFG_FACE_SIGN = 1'b1;

  // exp(-2^i) in unsigned Q30
  function automatic logic [DECAY_BITS-1:0] neg_pow(input logic [2:0] i);
    logic [DECAY_BITS-1:0] v;
    begin
      unique case (i)
        3'd0: v = 30'd395007542;
        3'd1: v = 30'd145315154;
        3'd2: v = 30'd19666267;
        3'd3: v = 30'd360200;
        3'd4: v = 30'd121;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

// File: sv/dcfu_decay.sv
`default_nettype none
// Pipelined exp(-dt*gamma) in unsigned Q30. Each Horner step takes two stages:
// the product r*p, then the divide by k done as a reciprocal multiply. A side
// payload of width PW travels alongside.
module dcfu_decay
  import dcfu_pkg::*;
#(
  parameter int FB = 16,
  parameter int GW = 31,
  parameter int PW = 8
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               adv,
  input  wire               in_vld,
  input  wire [31:0]        in_dt,
  input  wire [GW-1:0]      in_gam,
  input  wire [PW-1:0]      in_pay,
  output logic              out_vld,
  output logic [DECAY_BITS:0] out_dec,
  output logic [PW-1:0]     out_pay
);

  localparam int NS = 2 + 2*HORNER_STEPS + POW_COUNT;
  localparam int XW = 32 + GW + 1;
  localparam int RS = DECAY_BITS + 4;         // reciprocal shift
  localparam logic [DECAY_BITS:0] ONE = (DECAY_BITS+1)'(1) << DECAY_BITS;

  logic [NS-1:0]             vld_r;
  logic [PW-1:0]             pay_r [NS];
  logic [DECAY_BITS:0]       p_r   [1:NS-1];
  logic [DECAY_BITS-1:0]     rq_r  [1:NS-1];
  logic [4:0]                n_r   [1:NS-1];
  logic                      zero_r[1:NS-1];
  logic [XW-1:0]             prod_r;

  // stage 0: product dt*gamma
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r   <= XW'(in_dt) * XW'(in_gam);
      pay_r[0] <= in_pay;
    end
  end

  // stage 1: round, split into integer and fraction
  logic [XW-1:0] x_w;
  assign x_w = (prod_r + (XW'(1) << (FB-1))) >> FB;

  always_ff @(posedge clk) begin
    if (adv) begin
      pay_r[1]  <= pay_r[0];
      zero_r[1] <= (x_w >= (XW'(32) << FB));
      n_r[1]    <= x_w[FB+4:FB];
      rq_r[1]   <= DECAY_BITS'(x_w[FB-1:0]) << (DECAY_BITS - FB);
      p_r[1]    <= ONE;
    end
  end

  // Horner steps, then table multiplies
  for (genvar s = 2; s < NS; s++) begin : g_st
    logic [DECAY_BITS:0] p_nxt;
    if (s < 2 + 2*HORNER_STEPS) begin : g_h
      if ((s - 2) % 2 == 0) begin : g_mul
        // r*p, drop the Q30 fraction
        logic [2*DECAY_BITS:0] m;
        assign m = (2*DECAY_BITS+1)'(rq_r[s-1]) * (2*DECAY_BITS+1)'(p_r[s-1]);
        assign p_nxt = (DECAY_BITS+1)'(m >> DECAY_BITS);
      end else begin : g_div
        // divide by k through the rounded-up reciprocal; exact below 2^30
        localparam int K = HORNER_STEPS - (s - 2) / 2;
        localparam logic [RS:0] RCP =
          (RS+1)'(((64'd1 << RS) + 64'(K) - 64'd1) / 64'(K));
        logic [DECAY_BITS+RS+1:0] m;
        assign m = (DECAY_BITS+RS+2)'(p_r[s-1]) * (DECAY_BITS+RS+2)'(RCP);
        assign p_nxt = ONE - (DECAY_BITS+1)'(m >> RS);
      end
    end else begin : g_p
      localparam int I = s - 2 - 2*HORNER_STEPS;
      logic [2*DECAY_BITS:0] m;
      assign m = (2*DECAY_BITS+1)'(p_r[s-1]) * (2*DECAY_BITS+1)'(neg_pow(3'(I)));
      assign p_nxt = n_r[s-1][I] ? (DECAY_BITS+1)'(m >> DECAY_BITS) : p_r[s-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        pay_r[s]  <= pay_r[s-1];
        zero_r[s] <= zero_r[s-1];
        n_r[s]    <= n_r[s-1];
        rq_r[s]   <= rq_r[s-1];
        p_r[s]    <= p_nxt;
      end
    end
  end

  assign out_vld = vld_r[NS-1];
  assign out_dec = zero_r[NS-1] ? '0 : p_r[NS-1];
  assign out_pay = pay_r[NS-1];

  // decay never exceeds one
  a_dec_le_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> out_dec <= ONE) else $error("decay above one");
  a_vld_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> vld_r == $past(vld_r)) else $error("valid moved during stall");
  a_vld_reset: assert property (@(posedge clk)
    !rst_n |=> vld_r == '0) else $error("valid not cleared");

endmodule
`default_nettype wire

// File: sv/drude_cell_field_update_top.sv
`default_nettype none
// Drude cell field update. Accepts one cell request per cycle and returns
// current_next = dt*E + exp(-dt*g)*J and field_next = 2aE + s*b*curl - f*Jn,
// both rounded and saturated. A request passes 32 register stages: 27 in the
// decay pipeline (product, split, ten Horner steps of two stages each, five
// table multiplies), four for the current and field sums, and the output
// skid, whose head entry drives the outputs.
// Throughput is one request per cycle; a full two-entry skid at the output
// freezes the whole pipeline, and in_stall comes straight from its count
// register.
module drude_cell_field_update_top
  import dcfu_pkg::*;
#(
  parameter int FRACTION_BITS = 16,
  parameter int VALUE_WIDTH   = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_we,
  input  wire                          cfg_index,
  input  wire [31:0]                   cfg_data,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire signed [VALUE_WIDTH-1:0] in_field_now,
  input  wire signed [VALUE_WIDTH-1:0] in_current_now,
  input  wire [VALUE_WIDTH-2:0]        in_damping,
  input  wire signed [VALUE_WIDTH-1:0] in_coef_a,
  input  wire signed [VALUE_WIDTH-1:0] in_coef_b,
  input  wire signed [VALUE_WIDTH-1:0] in_coef_f,
  input  wire signed [VALUE_WIDTH-1:0] in_first_here,
  input  wire signed [VALUE_WIDTH-1:0] in_first_behind,
  input  wire signed [VALUE_WIDTH-1:0] in_second_here,
  input  wire signed [VALUE_WIDTH-1:0] in_second_behind,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic signed [VALUE_WIDTH-1:0] out_field_next,
  output logic signed [VALUE_WIDTH-1:0] out_current_next
);

  localparam int VW = VALUE_WIDTH;
  localparam int CW = VW + 2;                 // curl width
  localparam int EW = 2*VW + 8;               // field accumulator
  localparam int JW = 32 + VW + DECAY_BITS + 4;
  localparam int PW = 5*VW + CW;
  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  // configuration
  logic [31:0] time_step_r;
  logic        face_sign_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= 32'd32768;
      face_sign_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_TIME_STEP) time_step_r <= cfg_data;
      else face_sign_r <= cfg_data[0];
    end
  end

  // pipeline advance: freeze everything while the output skid is full
  logic adv;
  logic [1:0] sk_cnt_r;
  logic sk_full;
  assign sk_full  = (sk_cnt_r == 2'd2);
  assign adv      = !sk_full;
  assign in_stall = sk_full;

  // curl, then pack the side payload
  logic signed [CW-1:0] curl_w;
  assign curl_w = (CW'(in_first_here) - CW'(in_first_behind))
                - (CW'(in_second_here) - CW'(in_second_behind));

  logic [PW-1:0] pay_in, pay_out;
  assign pay_in = {in_field_now, in_current_now, in_coef_a, in_coef_b, in_coef_f, curl_w};

  logic              dv;
  logic [DECAY_BITS:0] dec;
  dcfu_decay #(.FB(FRACTION_BITS), .GW(VW-1), .PW(PW)) u_decay (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(in_valid && !in_stall),
    .in_dt(time_step_r), .in_gam(in_damping), .in_pay(pay_in),
    .out_vld(dv), .out_dec(dec), .out_pay(pay_out)
  );

  logic signed [VW-1:0] fld, cur, ca, cb, cf;
  logic signed [CW-1:0] crl;
  assign {fld, cur, ca, cb, cf, crl} = pay_out;

  // stage A: products for current and first field terms
  logic [3:0]            v_r;
  logic signed [JW-1:0]  jt_r, jd_r;
  logic signed [EW-1:0]  ea_r, eb_r;
  logic signed [VW-1:0]  cfa_r, cfb_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      jt_r  <= JW'($signed({1'b0, time_step_r})) * JW'(fld);
      jd_r  <= JW'($signed({1'b0, dec})) * JW'(cur);
      ea_r  <= EW'(ca) * EW'(fld);
      eb_r  <= EW'(cb) * EW'(crl);
      cfa_r <= cf;
    end
  end

  // stage B: sum current, round, saturate; combine field terms
  logic signed [JW-1:0] js_w, jr_w;
  logic signed [VW-1:0] jn_w;
  assign js_w = (jt_r <<< (DECAY_BITS - FRACTION_BITS)) + jd_r;
  assign jr_w = (js_w + (JW'(1) <<< (DECAY_BITS-1))) >>> DECAY_BITS;
  assign jn_w = (jr_w > JW'(VMAX)) ? VMAX : (jr_w < JW'(VMIN)) ? VMIN : VW'(jr_w);

  logic signed [VW-1:0] jn_r, jn2_r;
  logic signed [EW-1:0] e1_r, e2_r, fj_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      jn_r  <= jn_w;
      e1_r  <= (ea_r <<< 1) + (face_sign_r ? eb_r : -eb_r);
      cfb_r <= cfa_r;
    end
  end

  // stage C: f*Jn
  always_ff @(posedge clk) begin
    if (adv) begin
      fj_r  <= EW'(cfb_r) * EW'(jn_r);
      e2_r  <= e1_r;
      jn2_r <= jn_r;
    end
  end

  // stage D: final field sum, round, saturate
  logic signed [EW-1:0] er_w;
  logic signed [VW-1:0] en_w, en_r, jn3_r;
  assign er_w = (e2_r - fj_r + (EW'(1) <<< (FRACTION_BITS-1))) >>> FRACTION_BITS;
  assign en_w = (er_w > EW'(VMAX)) ? VMAX : (er_w < EW'(VMIN)) ? VMIN : VW'(er_w);
  always_ff @(posedge clk) begin
    if (adv) begin
      en_r  <= en_w;
      jn3_r <= jn2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[2:0], dv};
  end

  // output skid: two entries, pipeline freezes when full
  logic signed [VW-1:0] sk_f_r [2];
  logic signed [VW-1:0] sk_j_r [2];
  logic signed [VW-1:0] sk_f_nxt [2];
  logic signed [VW-1:0] sk_j_nxt [2];
  logic push, pop;
  assign push = adv && v_r[3];
  assign pop  = (sk_cnt_r != 2'd0) && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sk_cnt_r <= '0;
    end else begin
      sk_cnt_r <= sk_cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  logic [1:0] wr_at;
  assign wr_at = sk_cnt_r - {1'b0, pop};

  // shift out on pop, then drop the new result into the first free slot
  always_comb begin
    sk_f_nxt[0] = pop ? sk_f_r[1] : sk_f_r[0];
    sk_j_nxt[0] = pop ? sk_j_r[1] : sk_j_r[0];
    sk_f_nxt[1] = sk_f_r[1];
    sk_j_nxt[1] = sk_j_r[1];
    if (push) begin
      if (wr_at[0]) begin
        sk_f_nxt[1] = en_r;
        sk_j_nxt[1] = jn3_r;
      end else begin
        sk_f_nxt[0] = en_r;
        sk_j_nxt[0] = jn3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    sk_f_r[0] <= sk_f_nxt[0];
    sk_f_r[1] <= sk_f_nxt[1];
    sk_j_r[0] <= sk_j_nxt[0];
    sk_j_r[1] <= sk_j_nxt[1];
  end

  assign out_valid        = (sk_cnt_r != 2'd0);
  assign out_field_next   = sk_f_r[0];
  assign out_current_next = sk_j_r[0];

  a_sk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sk_cnt_r <= 2'd2) else $error("skid overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    sk_full |-> !push) else $error("push into full skid");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_field_next))
    else $error("stalled result changed");

endmodule
`default_nettype wire
